/* src/compare_conditional_sub_mod_defines.svh */
// Assertion macros for the compare/conditional-subtract block.
`ifndef COMPARE_CONDITIONAL_SUB_MOD_DEFINES_SVH
`define COMPARE_CONDITIONAL_SUB_MOD_DEFINES_SVH
`ifndef SYNTHESIS
`define CCSM_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) expr) \
    else $error("ccsm assertion failed");
`define CCSM_ASSERT_IMP(lbl, a, c) \
  `CCSM_ASSERT(lbl, (a) |-> (c))
`else
`define CCSM_ASSERT(lbl, expr)
`define CCSM_ASSERT_IMP(lbl, a, c)
`endif
`endif

/* src/ccsm_pkg.sv */
`default_nettype none
package ccsm_pkg;
  localparam int unsigned W = 64;
  localparam int unsigned DIV_STAGES = W;
  localparam int unsigned LATENCY = DIV_STAGES + 3;
  localparam int unsigned ADDR_W = 5;

  typedef enum logic [1:0] {
    REG_PREDICATE  = 2'd0,
    REG_BOUND      = 2'd1,
    REG_SUBTRAHEND = 2'd2,
    REG_MODULUS    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PRED_EQ    = 3'd0,
    PRED_LT    = 3'd1,
    PRED_LE    = 3'd2,
    PRED_FALSE = 3'd3,
    PRED_NE    = 3'd4,
    PRED_NLT   = 3'd5,
    PRED_NLE   = 3'd6,
    PRED_TRUE  = 3'd7
  } pred_t;

  function automatic logic test_holds(input logic [2:0] sel, input logic [W-1:0] a,
                                      input logic [W-1:0] b);
    logic res;
    case (pred_t'(sel))
      PRED_EQ:    res = (a == b);
      PRED_LT:    res = (a < b);
      PRED_LE:    res = (a <= b);
      PRED_FALSE: res = 1'b0;
      PRED_NE:    res = (a != b);
      PRED_NLT:   res = (a >= b);
      PRED_NLE:   res = (a > b);
      default:    res = 1'b1;
    endcase
    return res;
  endfunction

  // one restoring division step: shift in one bit, subtract modulus if it fits
  function automatic logic [W-1:0] div_step(input logic [W-1:0] r, input logic b,
                                            input logic [W-1:0] m);
    logic [W:0] t;
    logic [W:0] d;
    t = {r, b};
    d = t - {1'b0, m};
    return (t >= {1'b0, m}) ? d[W-1:0] : t[W-1:0];
  endfunction
endpackage
`default_nettype wire

/* src/compare_conditional_sub_mod.sv */
// Accepts one operand per clock whenever start is high; busy is always low, so
// items stream back to back. Each result appears on value, out_last and
// config_error for a single cycle marked by done, once its item has passed
// the registered bound compare, the bit-per-stage restoring reduction modulo
// modulus, and the conditional modular subtraction in the _a registers and
// value. The receiver cannot stall, so results must be captured when done is
// high. Registers are written through the APB port (8-byte spaced: predicate,
// bound, subtrahend, modulus); the user must do so only while no item is in
// flight, which the block itself does not enforce.
`default_nettype none
`include "compare_conditional_sub_mod_defines.svh"
module compare_conditional_sub_mod (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ccsm_pkg::W-1:0]       operand,
  input  wire logic                         in_last,
  output logic                              done,
  output logic [ccsm_pkg::W-1:0]            value,
  output logic                              out_last,
  output logic                              config_error,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ccsm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ccsm_pkg::W-1:0]       pwdata,
  output logic [ccsm_pkg::W-1:0]            prdata,
  output logic                              pready
);
  localparam int unsigned N = ccsm_pkg::DIV_STAGES;
  localparam int unsigned W = ccsm_pkg::W;

  logic [2:0]   predicate;
  logic [W-1:0] bound;
  logic [W-1:0] subtrahend;
  logic [W-1:0] modulus;
  logic [1:0]   reg_sel;
  logic         wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = paddr[ccsm_pkg::ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      predicate  <= 3'd0;
      bound      <= '0;
      subtrahend <= W'(1);
      modulus    <= W'(2);
    end else if (wr_en) begin
      case (ccsm_pkg::reg_idx_t'(reg_sel))
        ccsm_pkg::REG_PREDICATE:  predicate  <= pwdata[2:0];
        ccsm_pkg::REG_BOUND:      bound      <= pwdata;
        ccsm_pkg::REG_SUBTRAHEND: subtrahend <= pwdata;
        default:                  modulus    <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (ccsm_pkg::reg_idx_t'(reg_sel))
      ccsm_pkg::REG_PREDICATE:  prdata = {{(W-3){1'b0}}, predicate};
      ccsm_pkg::REG_BOUND:      prdata = bound;
      ccsm_pkg::REG_SUBTRAHEND: prdata = subtrahend;
      default:                  prdata = modulus;
    endcase
  end

  // reduction pipeline: stage k holds partial remainder and remaining bits
  logic         vld [0:N];
  logic         lst [0:N];
  logic         hit [0:N];
  logic [W-1:0] rem [0:N];
  logic [W-1:0] opsh [0:N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int k = 0; k < N; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    lst[0]  <= in_last;
    hit[0]  <= ccsm_pkg::test_holds(predicate, operand, bound);
    rem[0]  <= '0;
    opsh[0] <= operand;
    for (int k = 0; k < N; k++) begin
      lst[k+1]  <= lst[k];
      hit[k+1]  <= hit[k];
      rem[k+1]  <= ccsm_pkg::div_step(rem[k], opsh[k][W-1], modulus);
      if (k < N - 1) begin
        opsh[k+1] <= {opsh[k][W-2:0], 1'b0};
      end
    end
  end

  // subtract stage
  logic         vld_a;
  logic         lst_a;
  logic         apply_a;
  logic         err_a;
  logic         borrow_a;
  logic [W-1:0] red_a;
  logic [W-1:0] diff_a;
  logic [W:0]   diff_full;
  logic         err_now;

  assign diff_full = {1'b0, rem[N]} - {1'b0, subtrahend};
  assign err_now   = !(subtrahend < modulus);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld_a <= vld[N];
      done  <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    lst_a    <= lst[N];
    err_a    <= err_now;
    apply_a  <= hit[N] && !err_now;
    borrow_a <= diff_full[W];
    red_a    <= rem[N];
    diff_a   <= diff_full[W-1:0];
    out_last     <= lst_a;
    config_error <= err_a;
    if (!apply_a) begin
      value <= red_a;
    end else if (borrow_a) begin
      value <= diff_a + modulus;
    end else begin
      value <= diff_a;
    end
  end

  `CCSM_ASSERT_IMP(a_latency, start && !busy, ##(ccsm_pkg::LATENCY) done)
  `CCSM_ASSERT_IMP(a_no_spurious, done, $past(start, ccsm_pkg::LATENCY))
  `CCSM_ASSERT_IMP(a_last_follows, done, out_last == $past(in_last, ccsm_pkg::LATENCY))
endmodule
`default_nettype wire
